/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the magnitude capture block
// Implication checks, same-cycle and next-cycle, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define AMTC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define AMTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/amtc_pkg.sv */
// ----------------------------------------------------------------------------
// amtc_pkg
// Shared widths, register indexes, reset values and types of the
// magnitude-triggered capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package amtc_pkg;

   // Window storage
   localparam int WINDOW_DEPTH_DEF = 64;

   // Field widths
   localparam int TIME_W = 32;
   localparam int AXIS_W = 16;
   localparam int MAG_W  = 16;
   localparam int SUM_W  = 2 * MAG_W;
   localparam int AXES   = 3;

   // Configuration registers
   localparam int WL_W       = 7;
   localparam int THR_W      = 16;
   localparam int DLY_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_THRESHOLD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POST_TRIGGER_DELAY = 2'd2;

   localparam logic [WL_W-1:0]  WL_RESET  = 7'd64;
   localparam logic [THR_W-1:0] THR_RESET = 16'd4096;
   localparam logic [DLY_W-1:0] DLY_RESET = 16'd50;

   // One window entry
   typedef struct packed {
      logic [TIME_W-1:0] stamp;
      logic [MAG_W-1:0]  mag;
   } entry_type;

   // Magnitude unit status
   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] magnitude;
   } mag_result_type;

endpackage

`default_nettype wire

/* sv/amtc_mag.sv */
// ----------------------------------------------------------------------------
// amtc_mag
// Iterative magnitude unit: one shared squarer accumulates x^2+y^2+z^2 one
// axis at a time, then a restoring square root retires one root bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module amtc_mag (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic signed [amtc_pkg::AXIS_W-1:0] accel_x,
   input  wire logic signed [amtc_pkg::AXIS_W-1:0] accel_y,
   input  wire logic signed [amtc_pkg::AXIS_W-1:0] accel_z,
   output amtc_pkg::mag_result_type                result
);
   import amtc_pkg::*;

   localparam int CNT_W = $clog2(MAG_W);
   localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(AXES);
   localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(MAG_W - 1);
   localparam int REM_W = MAG_W + 1;

   typedef enum logic [3:0] {
      P_IDLE = 4'b0001,
      P_SQ   = 4'b0010,
      P_ROOT = 4'b0100,
      P_DONE = 4'b1000
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [AXIS_W-1:0] ax0_ff, ax0_in, ax1_ff, ax1_in, ax2_ff, ax2_in;
   logic [SUM_W-1:0] prod_ff, prod_in, acc_ff, acc_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [MAG_W-1:0] root_ff, root_in;

   logic signed [SUM_W-1:0] sq;
   logic [SUM_W-1:0]        acc_sum;
   logic [REM_W+1:0]        rem_sh, trial, diff;
   logic                    ge;

   // Shared squarer and root step datapath
   assign sq      = ax0_ff * ax0_ff;
   assign acc_sum = acc_ff + prod_ff;
   assign rem_sh  = {rem_ff, acc_ff[SUM_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign ge      = (rem_sh >= trial);
   assign diff    = rem_sh - trial;

   // Sequencer
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      ax0_in   = ax0_ff;
      ax1_in   = ax1_ff;
      ax2_in   = ax2_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      case (phase_ff)
         P_IDLE: begin
            if (start) begin
               ax0_in   = accel_x;
               ax1_in   = accel_y;
               ax2_in   = accel_z;
               prod_in  = '0;
               acc_in   = '0;
               cnt_in   = '0;
               phase_in = P_SQ;
            end
         end
         P_SQ: begin
            // square the head axis, fold the previous square in
            prod_in = $unsigned(sq);
            acc_in  = acc_sum;
            ax0_in  = ax1_ff;
            ax1_in  = ax2_ff;
            ax2_in  = '0;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == SQ_LAST) begin
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               phase_in = P_ROOT;
            end
         end
         P_ROOT: begin
            // one restoring step per cycle, two radicand bits in
            rem_in  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_in = {root_ff[MAG_W-2:0], ge};
            acc_in  = {acc_ff[SUM_W-3:0], 2'b00};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == ROOT_LAST) begin
               phase_in = P_DONE;
            end
         end
         P_DONE: begin
            phase_in = P_IDLE;
         end
         default: begin
            phase_in = P_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      ax0_ff  <= ax0_in;
      ax1_ff  <= ax1_in;
      ax2_ff  <= ax2_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign result.done      = (phase_ff == P_DONE);
   assign result.magnitude = root_ff;

endmodule

`default_nettype wire

/* sv/amtc_win.sv */
// ----------------------------------------------------------------------------
// amtc_win
// Circular window store: one write port, one read port with a read
// register that holds its data until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module amtc_win #(
   parameter  int DEPTH  = amtc_pkg::WINDOW_DEPTH_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_W-1:0]    wr_addr,
   input  wire amtc_pkg::entry_type  wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_W-1:0]    rd_addr,
   output amtc_pkg::entry_type       rd_data
);
   import amtc_pkg::*;

   entry_type ram_ff [DEPTH];
   entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/accel_magnitude_triggered_capture_top.sv */
// An item passes from accept through 4 square and fold steps, 16 root steps and the
// window update before the next accept can be taken. One item is in flight at a time,
// set by the shared squarer and root unit. A triggered window of N pairs is then sent,
// one beat per cycle while rsp_ready is high, before the next item is taken.
// Synchronous reset: window empty, capture disarmed, counter zero, registers at defaults.
// ----------------------------------------------------------------------------
// accel_magnitude_triggered_capture_top
// Computes accelerometer magnitude per sample, keeps a sliding window of
// (time, magnitude) pairs and bursts the window out after a delayed trigger.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_magnitude_triggered_capture_top #(
   parameter int WINDOW_DEPTH = amtc_pkg::WINDOW_DEPTH_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // configuration port
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [amtc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [amtc_pkg::CSR_DATA_W-1:0]        csr_wdata,
   // sample input
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [amtc_pkg::TIME_W-1:0]            req_timestamp,
   input  wire logic signed [amtc_pkg::AXIS_W-1:0]     req_accel_x,
   input  wire logic signed [amtc_pkg::AXIS_W-1:0]     req_accel_y,
   input  wire logic signed [amtc_pkg::AXIS_W-1:0]     req_accel_z,
   // window output
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [amtc_pkg::TIME_W-1:0]                 rsp_sample_time,
   output logic [amtc_pkg::MAG_W-1:0]                  rsp_sample_magnitude,
   output logic                                        rsp_last_of_window
);
   import amtc_pkg::*;

`include "assert_macros.svh"

   localparam int ADDR_W = $clog2(WINDOW_DEPTH);
   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam logic [WL_W-1:0]   DEPTH_WL   = WL_W'(WINDOW_DEPTH);
   localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(WINDOW_DEPTH);
   localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(WINDOW_DEPTH - 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CALC = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [WL_W-1:0]   wl_ff, wl_in;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [DLY_W-1:0]  dly_ff, dly_in;

   logic [TIME_W-1:0] stamp_ff;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [ADDR_W-1:0] wptr_ff, wptr_in;
   logic              armed_ff, armed_in;
   logic [DLY_W-1:0]  dcnt_ff, dcnt_in;
   logic [FILL_W-1:0] rd_k_ff, rd_k_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_last_ff, rsp_last_in;

   mag_result_type    mag_res;
   entry_type         wr_data;
   entry_type         rd_data;

   logic              req_fire;
   logic              wr_en;
   logic              rd_en;
   logic              emit;
   logic              armed_now;
   logic [WL_W-1:0]   len_wl;
   logic [FILL_W-1:0] len;
   logic [FILL_W:0]   fill_inc;
   logic [FILL_W-1:0] fill_next;
   logic [ADDR_W-1:0] wptr_next;
   logic [FILL_W-1:0] wptr_ext;
   logic [FILL_W-1:0] start_f;
   logic [FILL_W-1:0] rd_k_inc;
   logic              rd_last;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Configuration writes; unknown indexes are dropped
   always_comb begin
      wl_in  = wl_ff;
      thr_in = thr_ff;
      dly_in = dly_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WINDOW_LENGTH:      wl_in  = csr_wdata[WL_W-1:0];
            CSR_TRIGGER_THRESHOLD:  thr_in = csr_wdata[THR_W-1:0];
            CSR_POST_TRIGGER_DELAY: dly_in = csr_wdata[DLY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Magnitude unit
   amtc_mag u_mag (
      .clock   (clock),
      .reset   (reset),
      .start   (req_fire),
      .accel_x (req_accel_x),
      .accel_y (req_accel_y),
      .accel_z (req_accel_z),
      .result  (mag_res)
   );

   // Effective window length, clamped to 1..depth
   always_comb begin
      if (wl_ff == '0) begin
         len_wl = WL_W'(1);
      end else if (wl_ff > DEPTH_WL) begin
         len_wl = DEPTH_WL;
      end else begin
         len_wl = wl_ff;
      end
   end
   assign len = len_wl[FILL_W-1:0];

   // Window bookkeeping for the append
   assign fill_inc  = {1'b0, fill_ff} + 1'b1;
   assign fill_next = (fill_inc > {1'b0, len}) ? len : fill_inc[FILL_W-1:0];
   assign wptr_next = (wptr_ff == ADDR_LAST) ? '0 : wptr_ff + 1'b1;
   assign wptr_ext  = FILL_W'(wptr_next);
   assign start_f   = (wptr_ext >= fill_next) ? wptr_ext - fill_next
                                              : wptr_ext + DEPTH_FILL - fill_next;

   // Trigger decision
   assign armed_now = armed_ff || (mag_res.magnitude > thr_ff);
   assign emit      = (dcnt_ff >= dly_ff);

   // Burst read control
   assign rd_en    = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign rd_k_inc = rd_k_ff + 1'b1;
   assign rd_last  = (rd_k_inc == fill_ff);

   assign wr_en         = (state_ff == S_CALC) && mag_res.done;
   assign wr_data.stamp = stamp_ff;
   assign wr_data.mag   = mag_res.magnitude;

   // Main sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      wptr_in      = wptr_ff;
      armed_in     = armed_ff;
      dcnt_in      = dcnt_ff;
      rd_k_in      = rd_k_ff;
      rd_addr_in   = rd_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;

      // output register drains independently
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (mag_res.done) begin
               fill_in = fill_next;
               wptr_in = wptr_next;
               if (emit) begin
                  armed_in   = 1'b0;
                  dcnt_in    = '0;
                  rd_k_in    = '0;
                  rd_addr_in = start_f[ADDR_W-1:0];
                  state_in   = S_EMIT;
               end else begin
                  armed_in = armed_now;
                  if (armed_now) begin
                     dcnt_in = dcnt_ff + 1'b1;
                  end
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            if (rd_en) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = rd_last;
               rd_k_in      = rd_k_inc;
               rd_addr_in   = (rd_addr_ff == ADDR_LAST) ? '0 : rd_addr_ff + 1'b1;
               if (rd_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wl_ff        <= WL_RESET;
         thr_ff       <= THR_RESET;
         dly_ff       <= DLY_RESET;
         fill_ff      <= '0;
         wptr_ff      <= '0;
         armed_ff     <= 1'b0;
         dcnt_ff      <= '0;
         rd_k_ff      <= '0;
         rd_addr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wl_ff        <= wl_in;
         thr_ff       <= thr_in;
         dly_ff       <= dly_in;
         fill_ff      <= fill_in;
         wptr_ff      <= wptr_in;
         armed_ff     <= armed_in;
         dcnt_ff      <= dcnt_in;
         rd_k_ff      <= rd_k_in;
         rd_addr_ff   <= rd_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // Timestamp held while the magnitude is worked out
   always_ff @(posedge clock) begin
      if (req_fire) begin
         stamp_ff <= req_timestamp;
      end
   end

   // Window store
   amtc_win #(
      .DEPTH (WINDOW_DEPTH)
   ) u_win (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wptr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   // Result beat
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sample_time      = rd_data.stamp;
   assign rsp_sample_magnitude = rd_data.mag;
   assign rsp_last_of_window   = rsp_last_ff;

   // Checks
   `AMTC_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_ff <= DEPTH_FILL, "window fill above depth")
   `AMTC_ASSERT_IMPL(a_read_in_window, clock, reset, rd_en, rd_k_ff < fill_ff, "burst read past fill")
   `AMTC_ASSERT_NEXT(a_emit_disarms, clock, reset, wr_en && emit, (dcnt_ff == '0) && !armed_ff && (state_ff == S_EMIT), "trigger did not disarm")
   `AMTC_ASSERT_NEXT(a_accept_starts, clock, reset, req_fire, (state_ff == S_CALC) && !mag_res.done, "accepted sample not in calc")

endmodule

`default_nettype wire

/* verif/accel_magnitude_triggered_capture_top_tb.sv */
// ----------------------------------------------------------------------------
// accel_magnitude_triggered_capture_top_tb
// Drives accelerometer samples and register writes into the capture block.
// Every window beat that comes out is compared with a cycle-free software
// prediction of the magnitude window and post-trigger delay.
// ----------------------------------------------------------------------------
module accel_magnitude_triggered_capture_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import amtc_pkg::*;

   localparam int          CLK_PERIOD    = 10;
   localparam int          DEPTH         = WINDOW_DEPTH_DEF;
   localparam int          TOTAL_ITEMS   = 430;
   localparam int          SCRIPT_ROWS   = 33;
   // margin past one sample's run from accept to the next possible accept
   localparam int          SETTLE_CYCLES = 32;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          SQUEEZE_PHASE = 2;
   // slowest plausible run: 430 x (gap + processing + 64 beats at heavy stall);
   // allow about six times that
   localparam longint      TIME_LIMIT_NS = 64'd6_000_000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;
   typedef enum logic [1:0] {FLOW_OPEN, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_style_type;

   // one line of the directed script
   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_IDX_W-1:0]     index;
      logic [CSR_DATA_W-1:0]    wdata;
      logic [TIME_W-1:0]        stamp;
      logic [AXIS_W-1:0]        ax;
      logic [AXIS_W-1:0]        ay;
      logic [AXIS_W-1:0]        az;
      logic                     known;
      logic [MAG_W-1:0]         known_mag;
   } script_row_type;

   // one beat of an emitted window
   typedef struct packed {
      logic [TIME_W-1:0] stamp;
      logic [MAG_W-1:0]  mag;
      logic              last;
   } window_beat_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [TIME_W-1:0]            req_timestamp = '0;
   logic signed [AXIS_W-1:0]     req_accel_x = '0;
   logic signed [AXIS_W-1:0]     req_accel_y = '0;
   logic signed [AXIS_W-1:0]     req_accel_z = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [TIME_W-1:0]            rsp_sample_time;
   logic [MAG_W-1:0]             rsp_sample_magnitude;
   logic                         rsp_last_of_window;

   // predicted capture state and register copy
   logic [TIME_W-1:0]  win_stamp [DEPTH];
   logic [MAG_W-1:0]   win_mag [DEPTH];
   int unsigned        win_fill;
   int unsigned        win_slot;
   bit                 capture_armed;
   logic [DLY_W-1:0]   delay_count;
   logic [WL_W-1:0]    cfg_length;
   logic [THR_W-1:0]   cfg_threshold;
   logic [DLY_W-1:0]   cfg_delay;

   window_beat_type    window_beats_due [$];
   script_row_type     script [SCRIPT_ROWS];

   int unsigned        items_accepted;
   int unsigned        writes_applied;
   int unsigned        beats_seen;
   int unsigned        bursts_seen;
   int unsigned        error_count;
   int unsigned        burst_left;
   bit                 hold_wanted;

   accel_magnitude_triggered_capture_top i_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_timestamp        (req_timestamp),
      .req_accel_x          (req_accel_x),
      .req_accel_y          (req_accel_y),
      .req_accel_z          (req_accel_z),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_sample_time      (rsp_sample_time),
      .rsp_sample_magnitude (rsp_sample_magnitude),
      .rsp_last_of_window   (rsp_last_of_window)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // floor square root, one result bit at a time from the top
   function automatic logic [MAG_W-1:0] floor_root(input longint unsigned energy);
      logic [MAG_W-1:0]  root;
      longint unsigned   trial;
      root = '0;
      for (int b = MAG_W - 1; b >= 0; b--) begin
         trial = longint'(root) | (64'd1 << b);
         if (trial * trial <= energy) begin
            root = trial[MAG_W-1:0];
         end
      end
      return root;
   endfunction

   function automatic void capture_reset();
      win_fill      = 0;
      win_slot      = 0;
      capture_armed = 1'b0;
      delay_count   = '0;
      cfg_length    = WL_RESET;
      cfg_threshold = THR_RESET;
      cfg_delay     = DLY_RESET;
   endfunction

   // add one beat at the tail of the expected queue
   function automatic void queue_beat(input window_beat_type beat);
      window_beats_due = {window_beats_due, beat};
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] index,
                                          input logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_WINDOW_LENGTH: begin
            cfg_length = data[WL_W-1:0];
         end
         CSR_TRIGGER_THRESHOLD: begin
            cfg_threshold = data[THR_W-1:0];
         end
         CSR_POST_TRIGGER_DELAY: begin
            cfg_delay = data[DLY_W-1:0];
         end
         default: begin
         end
      endcase
   endfunction

   // append one sample, decide on the burst, queue the beats it causes
   function automatic void predict_capture(input logic [TIME_W-1:0] stamp,
                                           input logic signed [AXIS_W-1:0] ax,
                                           input logic signed [AXIS_W-1:0] ay,
                                           input logic signed [AXIS_W-1:0] az,
                                           input bit post);
      longint unsigned   energy;
      logic [MAG_W-1:0]  mag;
      int unsigned       span;
      int unsigned       oldest;
      int unsigned       pick;
      energy = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
             + longint'(az) * longint'(az);
      mag    = floor_root(energy);
      // out-of-range lengths clamp to the store
      span = (cfg_length == 0) ? 1 : ((cfg_length > DEPTH) ? DEPTH : cfg_length);
      win_stamp[win_slot] = stamp;
      win_mag[win_slot]   = mag;
      win_slot = (win_slot + 1) % DEPTH;
      win_fill = (win_fill + 1 > span) ? span : win_fill + 1;
      if (mag > cfg_threshold) begin
         capture_armed = 1'b1;
      end
      // delay met (or passed after a lowered delay): whole window, oldest first
      if (delay_count >= cfg_delay) begin
         oldest = (win_slot + DEPTH - win_fill) % DEPTH;
         for (int k = 0; k < win_fill; k++) begin
            pick = (oldest + k) % DEPTH;
            if (post) begin
               queue_beat(window_beat_type'{win_stamp[pick], win_mag[pick],
                                            k + 1 == win_fill});
            end
         end
         capture_armed = 1'b0;
         delay_count   = '0;
      end
      if (capture_armed) begin
         delay_count = delay_count + 1'b1;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Directed script rows
   // ---------------------------------------------------------------------------
   function automatic script_row_type csr_row(input logic [CSR_IDX_W-1:0] index,
                                              input logic [CSR_DATA_W-1:0] data);
      return script_row_type'{ROW_WRITE, index, data, '0, '0, '0, '0, 1'b0, '0};
   endfunction

   function automatic script_row_type sample_row(input logic [TIME_W-1:0] stamp,
                                                 input logic [AXIS_W-1:0] ax,
                                                 input logic [AXIS_W-1:0] ay,
                                                 input logic [AXIS_W-1:0] az);
      return script_row_type'{ROW_SAMPLE, '0, '0, stamp, ax, ay, az, 1'b0, '0};
   endfunction

   // single-pair window with zero delay: one beat, readable by hand
   function automatic script_row_type known_row(input logic [TIME_W-1:0] stamp,
                                                input logic [AXIS_W-1:0] ax,
                                                input logic [AXIS_W-1:0] ay,
                                                input logic [AXIS_W-1:0] az,
                                                input logic [MAG_W-1:0] mag);
      return script_row_type'{ROW_SAMPLE, '0, '0, stamp, ax, ay, az, 1'b1, mag};
   endfunction

   // ---------------------------------------------------------------------------
   // Drive helpers
   // ---------------------------------------------------------------------------
   task automatic flag_error(input string what);
      error_count++;
      $display("%0t ns  mismatch: %s", $time, what);
   endtask

   // sender stops and waits for the block to drain
   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (window_beats_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // valid stays high across chained writes; dropped after the last one
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data, input bit last);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_register(index, data);
      writes_applied++;
      if (last) begin
         csr_valid <= 1'b0;
      end
   endtask

   // bursts of back-to-back samples with a random gap before each burst
   task automatic offer_sample(input logic [TIME_W-1:0] stamp,
                               input logic [AXIS_W-1:0] ax,
                               input logic [AXIS_W-1:0] ay,
                               input logic [AXIS_W-1:0] az,
                               input bit known, input logic [MAG_W-1:0] known_mag);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_timestamp <= stamp;
      req_accel_x   <= ax;
      req_accel_y   <= ay;
      req_accel_z   <= az;
      do @(posedge clock); while (!req_ready);
      items_accepted++;
      predict_capture(stamp, ax, ay, az, !known);
      if (known) begin
         queue_beat(window_beat_type'{stamp, known_mag, 1'b1});
      end
   endtask

   function automatic logic [AXIS_W-1:0] random_axis(input int unsigned shape);
      logic [AXIS_W-1:0] corner [4];
      corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
      case (shape)
         0, 1: begin
            return AXIS_W'($urandom());
         end
         2, 3: begin
            return AXIS_W'(int'($urandom_range(0, 4000)) - 2000);
         end
         default: begin
            return corner[$urandom_range(0, 3)];
         end
      endcase
   endfunction

   // new register set for one random phase; extremes come up regularly
   task automatic pick_settings(input bit squeeze);
      logic [WL_W-1:0]       len_bits;
      logic [CSR_DATA_W-1:0] thr_word;
      logic [CSR_DATA_W-1:0] dly_word;
      case ($urandom_range(0, 7))
         0:       len_bits = 7'd0;
         1:       len_bits = 7'd64;
         2:       len_bits = 7'($urandom_range(65, 127));
         3:       len_bits = 7'($urandom_range(1, 4));
         default: len_bits = 7'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 5))
         0:       thr_word = '0;
         1:       thr_word = 16'hFFFF;
         2:       thr_word = 16'($urandom_range(0, 65535));
         default: thr_word = 16'($urandom_range(0, 3000));
      endcase
      case ($urandom_range(0, 11))
         0, 1:    dly_word = '0;
         2:       dly_word = 16'hFFFF;
         3:       dly_word = 16'($urandom_range(0, 65535));
         default: dly_word = 16'($urandom_range(0, 12));
      endcase
      if (squeeze) begin
         len_bits = 7'd64;
         dly_word = '0;
      end
      // upper data bits are don't-care for the length register
      write_reg(CSR_WINDOW_LENGTH, {9'($urandom_range(0, 511)), len_bits}, 1'b0);
      write_reg(CSR_TRIGGER_THRESHOLD, thr_word, 1'b0);
      if ($urandom_range(0, 3) == 0) begin
         write_reg(CSR_UNMAPPED, 16'($urandom()), 1'b0);
      end
      write_reg(CSR_POST_TRIGGER_DELAY, dly_word, 1'b1);
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin
      logic [TIME_W-1:0] stamp_cursor;
      int unsigned       phase;
      int unsigned       phase_items;
      int unsigned       shape;
      bit                last_write;

      capture_reset();
      script = '{
         // single-pair window, zero delay, unreachable threshold
         csr_row(CSR_WINDOW_LENGTH, 16'd1),
         csr_row(CSR_TRIGGER_THRESHOLD, 16'hFFFF),
         csr_row(CSR_POST_TRIGGER_DELAY, 16'd0),
         known_row(32'h0000_0000, 16'h0000, 16'h0000, 16'h0000, 16'd0),
         known_row(32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h8000, 16'd56755),
         known_row(32'h1234_5678, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd56754),
         known_row(32'hA5A5_A5A5, 16'd3, 16'd4, 16'd0, 16'd5),
         known_row(32'h5A5A_5A5A, -16'sd3, -16'sd4, -16'sd1, 16'd5),
         known_row(32'h8000_0001, 16'd0, 16'd0, 16'hFFFF, 16'd1),
         // zero length behaves as one
         csr_row(CSR_WINDOW_LENGTH, 16'd0),
         known_row(32'h0000_0002, 16'h8000, 16'h0000, 16'h0000, 16'd32768),
         // length above depth clamps; threshold equal does not arm
         csr_row(CSR_WINDOW_LENGTH, 16'hFFFF),
         csr_row(CSR_TRIGGER_THRESHOLD, 16'd5),
         csr_row(CSR_POST_TRIGGER_DELAY, 16'd3),
         csr_row(CSR_UNMAPPED, 16'h0000),
         sample_row(32'h0000_0100, 16'd3, 16'd4, 16'd0),
         sample_row(32'h0000_0101, 16'd3, 16'd4, 16'd1),
         sample_row(32'h0000_0102, 16'd6, 16'd0, 16'd0),
         sample_row(32'h0000_0103, 16'd0, 16'd0, 16'd0),
         sample_row(32'h0000_0104, 16'd0, 16'd0, 16'd0),
         sample_row(32'h0000_0105, 16'd1, 16'd1, 16'd1),
         // arm with a long delay, then lower it below the running count
         csr_row(CSR_TRIGGER_THRESHOLD, 16'd0),
         csr_row(CSR_POST_TRIGGER_DELAY, 16'd40),
         sample_row(32'h0000_0200, 16'd0, 16'd0, 16'd1),
         sample_row(32'h0000_0201, 16'd0, 16'd1, 16'd0),
         sample_row(32'h0000_0202, 16'd1, 16'd0, 16'd0),
         csr_row(CSR_POST_TRIGGER_DELAY, 16'd2),
         sample_row(32'h0000_0203, 16'd0, 16'd0, 16'd0),
         // shrink the window, then let it grow back
         csr_row(CSR_WINDOW_LENGTH, 16'd3),
         csr_row(CSR_POST_TRIGGER_DELAY, 16'd0),
         sample_row(32'h0000_0300, 16'd100, -16'sd200, 16'd300),
         csr_row(CSR_WINDOW_LENGTH, 16'd64),
         sample_row(32'h0000_0301, 16'hFFFF, 16'hFFFF, 16'hFFFF)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed script
      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         if (script[r].kind == ROW_WRITE) begin
            if (r > 0 && script[r-1].kind == ROW_SAMPLE) begin
               settle_block();
            end
            last_write = (r + 1 == SCRIPT_ROWS) || (script[r+1].kind != ROW_WRITE);
            write_reg(script[r].index, script[r].wdata, last_write);
         end else begin
            offer_sample(script[r].stamp, script[r].ax, script[r].ay, script[r].az,
                         script[r].known, script[r].known_mag);
         end
      end

      // random phases, each under a fresh register set
      stamp_cursor = $urandom();
      phase        = 0;
      while (items_accepted < TOTAL_ITEMS) begin
         settle_block();
         pick_settings(phase == SQUEEZE_PHASE);
         if (phase == SQUEEZE_PHASE) begin
            hold_wanted = 1'b1;
            phase_items = 24;
         end else begin
            phase_items = $urandom_range(6, 36);
         end
         repeat (phase_items) begin
            stamp_cursor = ($urandom_range(0, 15) == 0) ? $urandom()
                                                        : stamp_cursor + $urandom_range(1, 5000);
            shape = $urandom_range(0, 4);
            offer_sample(stamp_cursor, random_axis(shape), random_axis(shape),
                         random_axis(shape), 1'b0, '0);
         end
         phase++;
      end

      settle_block();
      $display("Covered %0d samples across %0d register writes: axis extremes, clamped lengths,",
               items_accepted, writes_applied);
      $display("zero and lowered delays, threshold ties, %0d beats in %0d windows checked.",
               beats_seen, bursts_seen);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Result side: beat check and receiver stall pattern
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : drain_side
      window_beat_type    due;
      logic               ready_next;
      flow_style_type     flow_style;
      int unsigned        style_left;
      int unsigned        hold_left;
      bit                 hold_done;
      bit [1:0]           tick;

      if (!reset && rsp_valid && rsp_ready) begin
         beats_seen++;
         if (rsp_last_of_window) begin
            bursts_seen++;
         end
         if (window_beats_due.size() == 0) begin
            flag_error($sformatf("unexpected beat time=%h mag=%0d",
                                 rsp_sample_time, rsp_sample_magnitude));
         end else begin
            due = window_beats_due.pop_front();
            if (rsp_sample_time !== due.stamp) begin
               flag_error($sformatf("sample_time %h, want %h", rsp_sample_time, due.stamp));
            end
            if (rsp_sample_magnitude !== due.mag) begin
               flag_error($sformatf("sample_magnitude %0d, want %0d (time %h)",
                                    rsp_sample_magnitude, due.mag, due.stamp));
            end
            if (rsp_last_of_window !== due.last) begin
               flag_error($sformatf("last_of_window %b, want %b (time %h)",
                                    rsp_last_of_window, due.last, due.stamp));
            end
         end
      end

      // long hold-off once, so the block backs up into its input
      if (hold_wanted && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      tick = tick + 1'b1;
      if (hold_left > 0) begin
         hold_left--;
         ready_next = 1'b0;
      end else begin
         if (style_left == 0) begin
            flow_style = flow_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(40, 160);
         end
         style_left--;
         case (flow_style)
            FLOW_OPEN:     ready_next = 1'b1;
            FLOW_LIGHT:    ready_next = ($urandom_range(0, 3) != 0);
            FLOW_HEAVY:    ready_next = ($urandom_range(0, 4) < 2);
            default:       ready_next = (tick != 2'd0);
         endcase
      end
      rsp_ready <= ready_next;
   end

   // ---------------------------------------------------------------------------
   // Run limit
   // ---------------------------------------------------------------------------
   initial begin
      #(TIME_LIMIT_NS);
      $display("Timeout with %0d beats still due after %0d samples",
               window_beats_due.size(), items_accepted);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/amtc_pkg.sv
sv/amtc_mag.sv
sv/amtc_win.sv
sv/accel_magnitude_triggered_capture_top.sv
verif/accel_magnitude_triggered_capture_top_tb.sv
